/* src/mlcm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mlcm_pkg;

   // Block configuration.
   localparam int NUM_CHANNELS = 4;    // channels that have a color table, 1..4
   localparam int TABLE_DEPTH  = 256;  // entries in each channel's table, 2..256
   localparam int TBL_AW       = $clog2(TABLE_DEPTH);
   localparam int SAMPLE_COUNT = 4;    // sample fields carried by every input item

   // Result queue behind the merge chain; it covers every voxel in flight.
   localparam int FIFO_DEPTH = 16;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int CREDIT_W   = FIFO_AW + 1;

   // Widths of the running sums (four 8-bit terms).
   localparam int ACC_W = 10;
   localparam int CNT_W = 3;
   localparam int LUM_W = 17;          // 30*R + 59*G + 11*B with R, G, B <= 1020

   // Luminance weights and the reciprocals that replace the divisions.
   localparam logic [6:0]  LUM_MUL_R   = 7'd30;
   localparam logic [6:0]  LUM_MUL_G   = 7'd59;
   localparam logic [6:0]  LUM_MUL_B   = 7'd11;
   localparam logic [17:0] LUM_RECIP   = 18'd167773;  // ceil(2^24 / 100)
   localparam int          LUM_SHIFT   = 24;
   localparam logic [9:0]  THIRD_RECIP = 10'd683;     // ceil(2^11 / 3)
   localparam int          THIRD_SHIFT = 11;
   localparam logic [7:0]  SAT_MAX     = 8'd255;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_VOXEL = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      CSR_CHANNEL_COUNT  = 3'd0,
      CSR_BUILD_ALPHA    = 3'd1,
      CSR_ALPHA_MAX_MODE = 3'd2,
      CSR_LUMINANCE_MODE = 3'd3,
      CSR_AVG_THRESHOLD  = 3'd4
   } csr_index_type;

   // One item as it walks down the chain of channel cells.
   typedef struct packed {
      logic                              is_voxel;
      logic [SAMPLE_COUNT-1:0][7:0]      samples;
      logic [1:0]                        tbl_channel;
      logic [7:0]                        tbl_index;
      logic [23:0]                       tbl_rgb;
      logic [ACC_W-1:0]                  acc_red;
      logic [ACC_W-1:0]                  acc_green;
      logic [ACC_W-1:0]                  acc_blue;
      logic [7:0]                        max_sample;
      logic [ACC_W-1:0]                  thr_sum;
      logic [CNT_W-1:0]                  thr_count;
   } token_type;

   typedef struct packed {
      logic [2:0] chans;
      logic [7:0] threshold;
   } cell_cfg_type;

   typedef struct packed {
      logic build;
      logic max_mode;
      logic lum_mode;
   } alpha_cfg_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } result_type;

endpackage

`default_nettype wire

/* src/mlcm_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface mlcm_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [7:0] sample_ch0;
   logic [7:0] sample_ch1;
   logic [7:0] sample_ch2;
   logic [7:0] sample_ch3;
   logic [1:0] table_channel;
   logic [7:0] table_index;
   logic [7:0] table_red;
   logic [7:0] table_green;
   logic [7:0] table_blue;

   modport source (
      output valid, opcode, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
             table_channel, table_index, table_red, table_green, table_blue,
      input  ready
   );
   modport sink (
      input  valid, opcode, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
             table_channel, table_index, table_red, table_green, table_blue,
      output ready
   );
endinterface

`default_nettype wire

/* src/mlcm_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface mlcm_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] alpha;

   modport source (
      output valid, red, green, blue, alpha,
      input  ready
   );
   modport sink (
      input  valid, red, green, blue, alpha,
      output ready
   );
endinterface

`default_nettype wire

/* src/mlcm_csr_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface mlcm_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] reg_index;
   logic [7:0] wr_data;

   modport source (
      output valid, reg_index, wr_data,
      input  ready
   );
   modport sink (
      input  valid, reg_index, wr_data,
      output ready
   );
endinterface

`default_nettype wire

/* src/mlcm_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module mlcm_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* src/mlcm_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

// One channel of the merge chain: owns that channel's color table and adds
// its contribution to the item: the table read is registered, then the sum.
module mlcm_cell
   import mlcm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic [1:0]   cell_id,
   input  wire cell_cfg_type cfg,
   input  wire logic         in_valid,
   input  wire token_type    in_tok,
   output logic              out_valid,
   output token_type         out_tok
);

   logic              mid_valid_ff;
   token_type         mid_tok_ff;
   logic              out_valid_ff;
   token_type         out_tok_ff;
   token_type         out_tok_in;

   logic              wr_en;
   logic              rd_en;
   logic [TBL_AW-1:0] rd_addr;
   logic [7:0]        in_sample;
   logic [7:0]        mid_sample;
   logic [23:0]       entry;
   logic              active;

   assign in_sample = in_tok.samples[cell_id];

   // Loads write only the table of the channel they name; out-of-range
   // indexes are dropped. Samples past the table read its last entry.
   assign wr_en = in_valid && !in_tok.is_voxel && (in_tok.tbl_channel == cell_id)
                  && (9'(in_tok.tbl_index) < 9'(TABLE_DEPTH));
   assign rd_en = in_valid && in_tok.is_voxel;
   assign rd_addr = (9'(in_sample) >= 9'(TABLE_DEPTH)) ? TBL_AW'(TABLE_DEPTH - 1)
                                                       : TBL_AW'(in_sample);

   mlcm_ram #(
      .WIDTH (24),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (TBL_AW'(in_tok.tbl_index)),
      .wr_data (in_tok.tbl_rgb),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (entry)
   );

   assign mid_sample = mid_tok_ff.samples[cell_id];
   assign active     = {1'b0, cell_id} < cfg.chans;

   always_comb begin
      out_tok_in = mid_tok_ff;
      if (mid_tok_ff.is_voxel && active) begin
         out_tok_in.acc_red   = mid_tok_ff.acc_red   + ACC_W'(entry[23:16]);
         out_tok_in.acc_green = mid_tok_ff.acc_green + ACC_W'(entry[15:8]);
         out_tok_in.acc_blue  = mid_tok_ff.acc_blue  + ACC_W'(entry[7:0]);
         if (mid_sample > mid_tok_ff.max_sample) begin
            out_tok_in.max_sample = mid_sample;
         end
         if (mid_sample > cfg.threshold) begin
            out_tok_in.thr_sum   = mid_tok_ff.thr_sum + ACC_W'(mid_sample);
            out_tok_in.thr_count = mid_tok_ff.thr_count + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mid_valid_ff <= in_valid;
         out_valid_ff <= mid_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      mid_tok_ff <= in_tok;
      out_tok_ff <= out_tok_in;
   end

   assign out_valid = out_valid_ff;
   assign out_tok   = out_tok_ff;

endmodule

`default_nettype wire

/* src/mlcm_alpha.sv */
`timescale 1ns / 1ps
`default_nettype none

// Two-stage finish: saturates the color sums and builds alpha. The divisions
// by 100 and by 3 are done as reciprocal multiplies in the second stage.
module mlcm_alpha
   import mlcm_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire alpha_cfg_type cfg,
   input  wire logic          in_valid,
   input  wire token_type     in_tok,
   output logic               out_valid,
   output result_type         out_res
);

   localparam int LP_W = LUM_W + 18;
   localparam int TP_W = 2 * ACC_W;

   function automatic logic [7:0] sat8(input logic [ACC_W-1:0] v);
      return (v > ACC_W'(SAT_MAX)) ? SAT_MAX : v[7:0];
   endfunction

   logic             s1_valid_ff;
   logic [7:0]       s1_red_ff;
   logic [7:0]       s1_green_ff;
   logic [7:0]       s1_blue_ff;
   logic [LUM_W-1:0] s1_lum_num_ff;
   logic [ACC_W-1:0] s1_sum_ff;
   logic [CNT_W-1:0] s1_count_ff;
   logic [7:0]       s1_max_ff;
   logic [LUM_W-1:0] lum_num_in;

   logic             out_valid_ff;
   result_type       out_res_ff;
   result_type       out_res_in;
   logic [LP_W-1:0]  lum_prod;
   logic [ACC_W-1:0] lum;
   logic [TP_W-1:0]  third_prod;
   logic [7:0]       mean;
   logic [7:0]       alpha;

   assign lum_num_in = LUM_W'(in_tok.acc_red)   * LUM_W'(LUM_MUL_R)
                     + LUM_W'(in_tok.acc_green) * LUM_W'(LUM_MUL_G)
                     + LUM_W'(in_tok.acc_blue)  * LUM_W'(LUM_MUL_B);

   always_ff @(posedge clock) begin
      s1_red_ff     <= sat8(in_tok.acc_red);
      s1_green_ff   <= sat8(in_tok.acc_green);
      s1_blue_ff    <= sat8(in_tok.acc_blue);
      s1_lum_num_ff <= lum_num_in;
      s1_sum_ff     <= in_tok.thr_sum;
      s1_count_ff   <= in_tok.thr_count;
      s1_max_ff     <= in_tok.max_sample;
   end

   // Exact floor(x / 100) for x below 199728, and floor(x / 3) for x <= 1020.
   assign lum_prod   = LP_W'(s1_lum_num_ff) * LP_W'(LUM_RECIP);
   assign lum        = lum_prod[LUM_SHIFT +: ACC_W];
   assign third_prod = TP_W'(s1_sum_ff) * TP_W'(THIRD_RECIP);

   always_comb begin
      case (s1_count_ff)
         CNT_W'(1): mean = s1_sum_ff[7:0];
         CNT_W'(2): mean = s1_sum_ff[8:1];
         CNT_W'(3): mean = third_prod[THIRD_SHIFT +: 8];
         CNT_W'(4): mean = s1_sum_ff[9:2];
         default:   mean = 8'd0;
      endcase
   end

   always_comb begin
      alpha = 8'd0;
      if (cfg.build) begin
         if (cfg.max_mode) begin
            alpha = cfg.lum_mode ? sat8(lum) : s1_max_ff;
         end else if (s1_count_ff != '0) begin
            alpha = mean;
         end else if (cfg.lum_mode) begin
            alpha = sat8(lum);
         end
      end
      out_res_in.red   = s1_red_ff;
      out_res_in.green = s1_green_ff;
      out_res_in.blue  = s1_blue_ff;
      out_res_in.alpha = alpha;
   end

   always_ff @(posedge clock) begin
      out_res_ff <= out_res_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= in_valid && in_tok.is_voxel;
         out_valid_ff <= s1_valid_ff;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_res   = out_res_ff;

endmodule

`default_nettype wire

/* src/multichannel_lut_color_merge.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir   Carries
// --------  ----  --------------------------------------------------------
// req_chan  in    load of one color table entry, or one voxel of samples
// rsp_chan  out   merged RGBA of one voxel (nothing for a load)
// csr_chan  in    register write: index and data
//
// One item is taken per cycle while req_chan.ready is high. A voxel's result
// reaches rsp_chan through the head register, the table read and add registers
// of each channel cell, the alpha stages and the result queue.
// Reset is synchronous and clears the registers, the chain and the queue;
// the color tables are not cleared and must be loaded before use.
// The chain never stops; finished results wait in a 16-entry queue, and
// req_chan.ready drops only while 16 voxels are in flight or queued.
module multichannel_lut_color_merge
   import mlcm_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   mlcm_req_if.sink   req_chan,
   mlcm_rsp_if.source rsp_chan,
   mlcm_csr_if.sink   csr_chan
);

   // Configuration registers.
   logic [2:0] channel_count_ff;
   logic       build_alpha_ff;
   logic       alpha_max_mode_ff;
   logic       luminance_mode_ff;
   logic [7:0] avg_threshold_ff;

   logic          csr_write;
   logic [2:0]    chans_eff;
   cell_cfg_type  cell_cfg;
   alpha_cfg_type alpha_cfg;

   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid && csr_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_count_ff  <= 3'd4;
         build_alpha_ff    <= 1'b0;
         alpha_max_mode_ff <= 1'b0;
         luminance_mode_ff <= 1'b0;
         avg_threshold_ff  <= 8'd10;
      end else if (csr_write) begin
         unique case (csr_chan.reg_index)
            CSR_CHANNEL_COUNT:  channel_count_ff  <= csr_chan.wr_data[2:0];
            CSR_BUILD_ALPHA:    build_alpha_ff    <= csr_chan.wr_data[0];
            CSR_ALPHA_MAX_MODE: alpha_max_mode_ff <= csr_chan.wr_data[0];
            CSR_LUMINANCE_MODE: luminance_mode_ff <= csr_chan.wr_data[0];
            CSR_AVG_THRESHOLD:  avg_threshold_ff  <= csr_chan.wr_data;
            default: ;
         endcase
      end
   end

   // A count of zero merges one channel; a count past the built channels
   // merges all of them.
   always_comb begin
      if (channel_count_ff == 3'd0) begin
         chans_eff = 3'd1;
      end else if (channel_count_ff > 3'(NUM_CHANNELS)) begin
         chans_eff = 3'(NUM_CHANNELS);
      end else begin
         chans_eff = channel_count_ff;
      end
   end

   assign cell_cfg.chans      = chans_eff;
   assign cell_cfg.threshold  = avg_threshold_ff;
   assign alpha_cfg.build     = build_alpha_ff;
   assign alpha_cfg.max_mode  = alpha_max_mode_ff;
   assign alpha_cfg.lum_mode  = luminance_mode_ff;

   // Input transfer. Every voxel takes one credit, returned when its result
   // leaves; this keeps room in the queue for all voxels in the chain.
   logic [CREDIT_W-1:0] credit_ff;
   logic                req_xfer;
   logic                voxel_xfer;
   logic                rsp_xfer;

   assign req_chan.ready = credit_ff != CREDIT_W'(FIFO_DEPTH);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign voxel_xfer     = req_xfer && (req_chan.opcode == OP_VOXEL);

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_ff + CREDIT_W'(voxel_xfer) - CREDIT_W'(rsp_xfer);
      end
   end

   // Chain head: the captured item with empty sums.
   logic      head_valid_ff;
   token_type head_tok_ff;
   token_type head_tok_in;

   always_comb begin
      head_tok_in             = '0;
      head_tok_in.is_voxel    = req_chan.opcode == OP_VOXEL;
      head_tok_in.samples[0]  = req_chan.sample_ch0;
      head_tok_in.samples[1]  = req_chan.sample_ch1;
      head_tok_in.samples[2]  = req_chan.sample_ch2;
      head_tok_in.samples[3]  = req_chan.sample_ch3;
      head_tok_in.tbl_channel = req_chan.table_channel;
      head_tok_in.tbl_index   = req_chan.table_index;
      head_tok_in.tbl_rgb     = {req_chan.table_red, req_chan.table_green,
                                 req_chan.table_blue};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= req_xfer;
      end
   end

   always_ff @(posedge clock) begin
      head_tok_ff <= head_tok_in;
   end

   // Chain of channel cells. Loads travel the chain like voxels, so each
   // table sees writes and reads in transfer order.
   logic      link_valid [NUM_CHANNELS + 1];
   token_type link_tok   [NUM_CHANNELS + 1];

   assign link_valid[0] = head_valid_ff;
   assign link_tok[0]   = head_tok_ff;

   for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_cell
      mlcm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_id   (2'(g)),
         .cfg       (cell_cfg),
         .in_valid  (link_valid[g]),
         .in_tok    (link_tok[g]),
         .out_valid (link_valid[g + 1]),
         .out_tok   (link_tok[g + 1])
      );
   end

   logic       push;
   result_type push_res;

   mlcm_alpha u_alpha (
      .clock     (clock),
      .reset     (reset),
      .cfg       (alpha_cfg),
      .in_valid  (link_valid[NUM_CHANNELS]),
      .in_tok    (link_tok[NUM_CHANNELS]),
      .out_valid (push),
      .out_res   (push_res)
   );

   // Result queue.
   result_type          fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]  wr_ptr_ff;
   logic [FIFO_AW-1:0]  rd_ptr_ff;
   logic [CREDIT_W-1:0] fill_ff;
   result_type          head_res;

   assign rsp_xfer = rsp_chan.valid && rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= push_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_AW'(1);
         end
         if (rsp_xfer) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_AW'(1);
         end
         fill_ff <= fill_ff + CREDIT_W'(push) - CREDIT_W'(rsp_xfer);
      end
   end

   assign head_res       = fifo_ff[rd_ptr_ff];
   assign rsp_chan.valid = fill_ff != '0;
   assign rsp_chan.red   = head_res.red;
   assign rsp_chan.green = head_res.green;
   assign rsp_chan.blue  = head_res.blue;
   assign rsp_chan.alpha = head_res.alpha;

   // Credits never run past the queue size.
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= CREDIT_W'(FIFO_DEPTH))
      else $error("credit count above queue depth");

   // Queued results are a subset of the voxels holding credits.
   a_fill_le_credit: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= credit_ff)
      else $error("queue holds more results than outstanding voxels");

   // The chain never delivers into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (fill_ff != CREDIT_W'(FIFO_DEPTH)))
      else $error("result pushed into full queue");

   // A result can only appear while some voxel holds a credit.
   a_push_has_credit: assert property (@(posedge clock) disable iff (reset)
      push |-> (credit_ff != '0))
      else $error("result pushed with no voxel outstanding");

endmodule

`default_nettype wire

/* sim/mlcm_merge_checker.sv */
`timescale 1ns / 1ps

// Watches the three channels of the color merge block. It keeps a mirror of
// the color tables and the registers, predicts the RGBA value of every voxel
// and compares each result with the oldest prediction still waiting.
module mlcm_merge_checker
   import mlcm_pkg::*;
(
   input  logic clock,
   input  logic reset,
   mlcm_req_if  req_mon,
   mlcm_rsp_if  rsp_mon,
   mlcm_csr_if  csr_mon,
   output int   mismatches,
   output int   outstanding
);

   logic [23:0] color_lut [NUM_CHANNELS][TABLE_DEPTH];
   logic [2:0]  chan_count;
   logic        alpha_on;
   logic        max_mode;
   logic        lum_fallback;
   logic [7:0]  threshold;
   result_type  expected_rgba [$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   task automatic report_mismatch(input string msg);
      if (mismatches < 200)
         $display("%0t: MISMATCH %s", $time, msg);
      mismatches++;
   endtask

   function automatic logic [7:0] clip255(input int unsigned v);
      return (v > 255) ? 8'd255 : v[7:0];
   endfunction

   function automatic result_type merge_voxel(input logic [3:0][7:0] smp);
      int unsigned chans;
      int unsigned lut_idx;
      int unsigned red_sum, green_sum, blue_sum;
      int unsigned peak, above_sum, above_cnt, alpha;
      logic [23:0] entry;
      result_type  res;
      chans = chan_count;
      if (chans == 0)
         chans = 1;
      if (chans > NUM_CHANNELS)
         chans = NUM_CHANNELS;
      red_sum   = 0;
      green_sum = 0;
      blue_sum  = 0;
      peak      = 0;
      above_sum = 0;
      above_cnt = 0;
      alpha     = 0;
      for (int i = 0; i < chans; i++) begin
         lut_idx   = (smp[i] < TABLE_DEPTH) ? smp[i] : TABLE_DEPTH - 1;
         entry     = color_lut[i][lut_idx];
         red_sum   += entry[23:16];
         green_sum += entry[15:8];
         blue_sum  += entry[7:0];
         if (smp[i] > peak)
            peak = smp[i];
         if (smp[i] > threshold) begin
            above_sum += smp[i];
            above_cnt++;
         end
      end
      if (alpha_on) begin
         if (max_mode)
            alpha = peak;
         if (!max_mode && above_cnt > 0)
            alpha = above_sum / above_cnt;
         else if (lum_fallback)
            alpha = (30 * red_sum + 59 * green_sum + 11 * blue_sum) / 100;
      end
      res.red   = clip255(red_sum);
      res.green = clip255(green_sum);
      res.blue  = clip255(blue_sum);
      res.alpha = clip255(alpha);
      return res;
   endfunction

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         chan_count   = 3'd4;
         alpha_on     = 1'b0;
         max_mode     = 1'b0;
         lum_fallback = 1'b0;
         threshold    = 8'd10;
         expected_rgba.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_index_type'(csr_mon.reg_index))
               CSR_CHANNEL_COUNT:  chan_count   = csr_mon.wr_data[2:0];
               CSR_BUILD_ALPHA:    alpha_on     = csr_mon.wr_data[0];
               CSR_ALPHA_MAX_MODE: max_mode     = csr_mon.wr_data[0];
               CSR_LUMINANCE_MODE: lum_fallback = csr_mon.wr_data[0];
               CSR_AVG_THRESHOLD:  threshold    = csr_mon.wr_data;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.opcode == OP_LOAD) begin
               if (req_mon.table_channel < NUM_CHANNELS && req_mon.table_index < TABLE_DEPTH)
                  color_lut[req_mon.table_channel][req_mon.table_index] =
                     {req_mon.table_red, req_mon.table_green, req_mon.table_blue};
            end else begin
               expected_rgba.push_back(merge_voxel({req_mon.sample_ch3, req_mon.sample_ch2,
                                                    req_mon.sample_ch1, req_mon.sample_ch0}));
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.red, rsp_mon.green, rsp_mon.blue, rsp_mon.alpha};
            if (expected_rgba.size() == 0) begin
               report_mismatch($sformatf("result %p with no voxel pending", got));
            end else begin
               want = expected_rgba.pop_front();
               if (got.red !== want.red)
                  report_mismatch($sformatf("red got %0d want %0d", got.red, want.red));
               if (got.green !== want.green)
                  report_mismatch($sformatf("green got %0d want %0d", got.green, want.green));
               if (got.blue !== want.blue)
                  report_mismatch($sformatf("blue got %0d want %0d", got.blue, want.blue));
               if (got.alpha !== want.alpha)
                  report_mismatch($sformatf("alpha got %0d want %0d", got.alpha, want.alpha));
            end
         end
      end
      outstanding = expected_rgba.size();
   end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

// Top of the color merge testbench. This module only makes stimulus and
// gives the verdict; the checker beside the block predicts and compares.
//
// The run is one directed part followed by nine phases of random items.
// Every phase programs all five registers while the block is idle, so the
// run walks through channel counts from zero (taken as one) to seven (taken
// as four), both alpha modes, the luminance fallback and thresholds at both
// ends of their range.
module tb;
   import mlcm_pkg::*;

   // Long enough for an item still in the chain to leave it before the registers are touched again.
   localparam int DRAIN_CYCLES    = 2 * NUM_CHANNELS + 3 + 4;
   localparam int ITEMS_PER_PHASE = 200;
   localparam int HOLDOFF_CYCLES  = 300;
   localparam int PHASES          = 9;

   // One input item as the sender sees it.
   typedef struct {
      opcode_type          op;
      logic [3:0][7:0]     smp;
      logic [1:0]          tch;
      logic [7:0]          tidx;
      logic [7:0]          t_red;
      logic [7:0]          t_green;
      logic [7:0]          t_blue;
   } merge_item_t;

   // Register settings of the random phases, one column per phase.
   int unsigned cfg_count [PHASES] = '{4, 1, 0, 7, 2, 3, 4, 5, 4};
   bit          cfg_alpha [PHASES] = '{1, 1, 1, 1, 0, 1, 1, 1, 1};
   bit          cfg_maxm  [PHASES] = '{0, 1, 0, 1, 1, 0, 0, 0, 1};
   bit          cfg_lum   [PHASES] = '{1, 0, 0, 1, 1, 1, 0, 1, 0};
   int unsigned cfg_thr   [PHASES] = '{10, 0, 255, 128, 50, 255, 0, 200, 10};

   logic clock = 1'b0;
   logic reset;
   int   mismatches;
   int   outstanding;

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned cur_count;
   bit          holdoff_go = 1'b0;
   logic        holdoff_active;

   // Which table entries hold a known value. On the channels it merges, a voxel
   // only indexes entries that were loaded, since an unwritten entry has no defined value.
   bit lut_written   [NUM_CHANNELS][TABLE_DEPTH];
   int written_idx   [NUM_CHANNELS][$];
   int last_load_idx [NUM_CHANNELS];

   mlcm_req_if req_if ();
   mlcm_rsp_if rsp_if ();
   mlcm_csr_if csr_if ();

   multichannel_lut_color_merge i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   mlcm_merge_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_if),
      .rsp_mon     (rsp_if),
      .csr_mon     (csr_if),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // The run ends here if the block stops making progress.
   initial begin
      #4_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // Result side. Ready is redrawn every cycle from the current idle rate,
   // and it is held low for the whole of the long hold-off.
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_if.ready <= !holdoff_active && ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Long receiver hold-off. The sender keeps offering items meanwhile, so
   // the result queue fills up and the block has to stall its input.
   initial begin
      holdoff_active = 1'b0;
      wait (holdoff_go);
      @(negedge clock);
      holdoff_active <= 1'b1;
      repeat (HOLDOFF_CYCLES) @(negedge clock);
      holdoff_active <= 1'b0;
   end

   // Color bytes lean toward the ends of the range so that the sums saturate
   // often and stay small often.
   function automatic logic [7:0] color_byte();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 15)
         return 8'd0;
      if (roll < 30)
         return 8'd255;
      return 8'($urandom_range(0, 255));
   endfunction

   // Fields that an item does not use carry random values all the same.
   function automatic merge_item_t load_item(input logic [1:0] ch, input logic [7:0] idx,
                                             input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
      merge_item_t it;
      it.op      = OP_LOAD;
      it.smp     = {8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
      it.tch     = ch;
      it.tidx    = idx;
      it.t_red   = r;
      it.t_green = g;
      it.t_blue  = b;
      return it;
   endfunction

   function automatic merge_item_t voxel_item(input logic [3:0][7:0] smp);
      merge_item_t it;
      it.op      = OP_VOXEL;
      it.smp     = smp;
      it.tch     = 2'($urandom);
      it.tidx    = 8'($urandom);
      it.t_red   = 8'($urandom);
      it.t_green = 8'($urandom);
      it.t_blue  = 8'($urandom);
      return it;
   endfunction

   // Random mix of table loads and voxels. For a merged channel, a quarter of
   // the samples hit the entry loaded last on that channel, which checks that
   // a load is seen by a voxel right behind it; the others pick any loaded
   // entry. Channels beyond the count are not read and take any value.
   function automatic merge_item_t random_item();
      int unsigned      chans;
      logic [3:0][7:0]  smp;
      if ($urandom_range(0, 99) < 40)
         return load_item(2'($urandom), 8'($urandom), color_byte(), color_byte(), color_byte());
      chans = (cur_count == 0) ? 1 : (cur_count > NUM_CHANNELS) ? NUM_CHANNELS : cur_count;
      for (int i = 0; i < SAMPLE_COUNT; i++) begin
         smp[i] = 8'($urandom);
         if (i < chans) begin
            if ($urandom_range(0, 99) < 25)
               smp[i] = 8'(last_load_idx[i]);
            else
               smp[i] = 8'(written_idx[i][$urandom_range(0, written_idx[i].size() - 1)]);
         end
      end
      return voxel_item(smp);
   endfunction

   // Offers one item and returns at the falling edge after its transfer.
   // Valid stays high into the next item unless an idle gap is drawn.
   task automatic send_item(input merge_item_t it);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.opcode        <= it.op;
      req_if.sample_ch0    <= it.smp[0];
      req_if.sample_ch1    <= it.smp[1];
      req_if.sample_ch2    <= it.smp[2];
      req_if.sample_ch3    <= it.smp[3];
      req_if.table_channel <= it.tch;
      req_if.table_index   <= it.tidx;
      req_if.table_red     <= it.t_red;
      req_if.table_green   <= it.t_green;
      req_if.table_blue    <= it.t_blue;
      if (it.op == OP_LOAD && it.tch < NUM_CHANNELS && it.tidx < TABLE_DEPTH) begin
         if (!lut_written[it.tch][it.tidx])
            written_idx[it.tch].push_back(it.tidx);
         lut_written[it.tch][it.tidx] = 1'b1;
         last_load_idx[it.tch]        = it.tidx;
      end
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // One register write; valid is left high so that writes run back to back.
   task automatic write_reg(input csr_index_type idx, input logic [7:0] data);
      csr_if.valid     <= 1'b1;
      csr_if.reg_index <= idx;
      csr_if.wr_data   <= data;
      @(posedge clock);
      while (!csr_if.ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic apply_settings(input int p);
      write_reg(CSR_CHANNEL_COUNT, 8'(cfg_count[p]));
      write_reg(CSR_BUILD_ALPHA, 8'(cfg_alpha[p]));
      write_reg(CSR_ALPHA_MAX_MODE, 8'(cfg_maxm[p]));
      write_reg(CSR_LUMINANCE_MODE, 8'(cfg_lum[p]));
      write_reg(CSR_AVG_THRESHOLD, 8'(cfg_thr[p]));
      csr_if.valid <= 1'b0;
      cur_count = cfg_count[p];
   endtask

   // Waits until every voxel has come back, then lets the chain run empty so
   // that no table load is still on its way when the registers change.
   task automatic settle();
      req_if.valid <= 1'b0;
      while (outstanding != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      reset                = 1'b1;
      req_if.valid         = 1'b0;
      req_if.opcode        = OP_LOAD;
      req_if.sample_ch0    = 8'd0;
      req_if.sample_ch1    = 8'd0;
      req_if.sample_ch2    = 8'd0;
      req_if.sample_ch3    = 8'd0;
      req_if.table_channel = 2'd0;
      req_if.table_index   = 8'd0;
      req_if.table_red     = 8'd0;
      req_if.table_green   = 8'd0;
      req_if.table_blue    = 8'd0;
      csr_if.valid         = 1'b0;
      csr_if.reg_index     = CSR_CHANNEL_COUNT;
      csr_if.wr_data       = 8'd0;
      send_idle_pct        = 8;
      recv_idle_pct        = 66;
      cur_count            = 4;

      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, run with the registers as reset leaves them: the
      // lowest and highest entry of every table, all-zero and all-full
      // voxels, alternating extremes, and a voxel that reads an entry
      // rewritten by the load right before it.
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
         send_item(load_item(2'(ch), 8'd0, 8'd0, 8'd0, 8'd0));
         send_item(load_item(2'(ch), 8'(TABLE_DEPTH - 1), 8'd255, 8'd255, 8'd255));
      end
      send_item(voxel_item({8'd0, 8'd0, 8'd0, 8'd0}));
      send_item(voxel_item({8'd255, 8'd255, 8'd255, 8'd255}));
      send_item(voxel_item({8'd0, 8'd255, 8'd0, 8'd255}));
      send_item(voxel_item({8'd255, 8'd0, 8'd255, 8'd0}));
      send_item(load_item(2'd2, 8'(TABLE_DEPTH - 1), 8'h12, 8'h34, 8'h56));
      send_item(voxel_item({8'd255, 8'd255, 8'd255, 8'd255}));
      settle();

      // Random phases. The first third idles the receiver hard, the second
      // the sender, and the last runs at full rate on both sides, with the
      // long receiver hold-off at its start.
      for (int p = 0; p < PHASES; p++) begin
         if (p == 3) begin
            send_idle_pct = 66;
            recv_idle_pct = 8;
         end
         if (p == 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         apply_settings(p);
         if (p == 6)
            holdoff_go = 1'b1;
         repeat (ITEMS_PER_PHASE) send_item(random_item());
         settle();
      end

      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

/* sim.f */
src/mlcm_pkg.sv
src/mlcm_req_if.sv
src/mlcm_rsp_if.sv
src/mlcm_csr_if.sv
src/mlcm_ram.sv
src/mlcm_cell.sv
src/mlcm_alpha.sv
src/multichannel_lut_color_merge.sv
sim/mlcm_merge_checker.sv
sim/tb.sv
